[src/esc_pkg.sv]
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and calendar constants for the epoch seconds to calendar block.
// ----------------------------------------------------------------------------
package esc_pkg;

    typedef struct packed {
        logic vld;
        logic dat;
    } t_bitstr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STREAM,
        ST_YEAR,
        ST_LEAP,
        ST_FIX,
        ST_MONTH,
        ST_OUT
    } t_state;

    localparam int unsigned DIV_MIN   = 60;
    localparam int unsigned DIV_HOUR  = 24;
    localparam int unsigned DIV_YEAR  = 365;
    localparam int unsigned DIV_WEEK  = 7;
    localparam int unsigned DIV_CENT  = 25;

    localparam int unsigned EPOCH_YEAR    = 1970;
    localparam int unsigned BASE_YEAR     = 1900;
    localparam int unsigned DAYS_PER_YEAR = 365;
    localparam int unsigned EPOCH_WDAY    = 4;
    localparam int unsigned LEAPS_BEFORE_EPOCH =
        (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100 + (EPOCH_YEAR - 1) / 400;

    localparam logic [3:0] MONTH_FEB  = 4'd1;
    localparam logic [3:0] MONTH_LAST = 4'd11;

    localparam logic [4:0] MONTH_LEN [0:11] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

endpackage

[src/esc_divcell.sv]
// ----------------------------------------------------------------------------
// esc_divcell
// Bit-serial restoring divider by a constant. Takes the dividend MSB first,
// one bit a cycle, and emits the quotient bits as a registered stream.
// ----------------------------------------------------------------------------
module esc_divcell #(
    parameter int unsigned DIVISOR = 60
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clr,
    input  esc_pkg::t_bitstr             i_str,
    output esc_pkg::t_bitstr             o_str,
    output logic [$clog2(DIVISOR)-1:0]   o_rem
);
    import esc_pkg::*;

    localparam int RW = $clog2(DIVISOR);

    logic [RW-1:0] r_rem;
    logic [RW-1:0] n_rem;
    t_bitstr       r_str;
    t_bitstr       n_str;
    logic [RW:0]   w_x;
    logic          w_ge;

    assign w_x  = {r_rem, i_str.dat};
    assign w_ge = (w_x >= (RW + 1)'(DIVISOR));

    always_comb begin
        n_rem     = r_rem;
        n_str.vld = i_str.vld;
        n_str.dat = i_str.vld & w_ge;
        if (i_str.vld) begin
            if (w_ge) begin
                n_rem = RW'(w_x - (RW + 1)'(DIVISOR));
            end else begin
                n_rem = w_x[RW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_str <= '0;
            r_rem <= '0;
        end else begin
            r_str <= n_str;
            r_rem <= n_rem;
        end
    end

    assign o_str = r_str;
    assign o_rem = r_rem;

endmodule

[src/epoch_seconds_to_calendar.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts a count of seconds since 1970-01-01 00:00:00 into Gregorian
// calendar fields: second, minute, hour, day of month, month, year, day of
// year and weekday.
//
// Input channel: i_in_valid / o_in_ready carry i_epoch_seconds. Output
// channel: o_out_valid / i_out_ready carry the calendar fields, one result
// for every request.
// The time value runs MSB first, one bit a cycle, through a chain of serial
// dividers (/60, /60, /24, then /365 and /7 side by side); a serial /25
// divider then finds the centuries for the leap-year count, and a month
// scan walks at most twelve months, one a cycle. One request is in flight
// at a time: o_in_ready returns in the cycle after the result enters the
// output register, so a new request is taken only once the previous result
// has been loaded into the output register.
// Reset clears the sequencer and the output valid. A stalled receiver holds
// the result in the output register; a new request is still taken, and its
// result waits until the held one is taken.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar #(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [TIME_BITS-1:0] i_epoch_seconds,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [5:0]           o_second_of_minute,
    output logic [5:0]           o_minute_of_hour,
    output logic [4:0]           o_hour_of_day,
    output logic [4:0]           o_day_of_month,
    output logic [3:0]           o_month_index,
    output logic [7:0]           o_years_since_1900,
    output logic [8:0]           o_day_of_year,
    output logic [2:0]           o_weekday
);
    import esc_pkg::*;

    localparam int Q_W    = TIME_BITS - 24;
    localparam int Y_W    = ((Q_W > 11) ? Q_W : 11) + 1;
    localparam int A_W    = Y_W - 2;
    localparam int B_W    = A_W - 4;
    localparam int R_W    = A_W + 1;
    localparam int CNT_W  = $clog2(TIME_BITS + 4);
    localparam int MIN_W  = $clog2(DIV_MIN);
    localparam int HOUR_W = $clog2(DIV_HOUR);
    localparam int YEAR_W = $clog2(DIV_YEAR);
    localparam int WEEK_W = $clog2(DIV_WEEK);
    localparam int CENT_W = $clog2(DIV_CENT);

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]     r_cnt;
    logic [TIME_BITS-1:0] r_tsh;
    logic [Q_W-1:0]       r_q;
    logic [Y_W-1:0]       r_y0;
    logic [A_W-1:0]       r_ash;
    logic [B_W-1:0]       r_b;
    logic [R_W-1:0]       r_rem;
    logic [R_W-1:0]       n_rem;
    logic [3:0]           r_mon;
    logic [7:0]           r_yr;
    logic [7:0]           n_yr;
    logic [8:0]           r_doy;
    logic                 r_leap;
    logic                 n_leap;
    logic                 r_ovld;

    logic [5:0] r_out_sec;
    logic [5:0] r_out_min;
    logic [4:0] r_out_hour;
    logic [4:0] r_out_dom;
    logic [3:0] r_out_mon;
    logic [7:0] r_out_yr;
    logic [8:0] r_out_doy;
    logic [2:0] r_out_wday;

    logic s_accept;
    logic s_stream_end;
    logic s_leap_end;
    logic s_month_done;
    logic s_load_out;
    logic s_clr_cent;

    t_bitstr w_src;
    t_bitstr w_s1;
    t_bitstr w_s2;
    t_bitstr w_s3;
    t_bitstr w_s365;
    t_bitstr w_acent;
    t_bitstr w_s25;

    logic [MIN_W-1:0]  w_sec;
    logic [MIN_W-1:0]  w_min;
    logic [HOUR_W-1:0] w_hour;
    logic [YEAR_W-1:0] w_r365;
    logic [WEEK_W-1:0] w_d7;
    logic [CENT_W-1:0] w_c25;

    logic [Y_W-1:0] w_y0;
    logic [A_W-1:0] w_extra;
    logic           w_corr;
    logic [R_W-1:0] w_fwd;
    logic [R_W-1:0] w_back;
    logic           w_leap0;
    logic           w_leap1;
    logic           w_wrap;
    logic [4:0]     w_len;
    logic [2:0]     w_wday;

    // ---------------------------------------------------------------- control
    assign s_stream_end = (r_cnt == CNT_W'(TIME_BITS + 3));
    assign s_leap_end   = (r_cnt == CNT_W'(A_W));
    assign s_month_done = (r_mon == MONTH_LAST) || (r_rem < R_W'(w_len));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_STREAM;
                end
            end
            ST_STREAM: begin
                if (s_stream_end) begin
                    n_state = ST_YEAR;
                end
            end
            ST_YEAR: begin
                n_state = ST_LEAP;
            end
            ST_LEAP: begin
                if (s_leap_end) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                n_state = ST_MONTH;
            end
            ST_MONTH: begin
                if (s_month_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ovld || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        s_accept   = 1'b0;
        s_load_out = 1'b0;
        s_clr_cent = 1'b0;
        w_src      = '0;
        w_acent    = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                s_accept   = i_in_valid;
            end
            ST_STREAM: begin
                w_src.vld = (r_cnt < CNT_W'(TIME_BITS));
                w_src.dat = r_tsh[TIME_BITS-1];
            end
            ST_YEAR: begin
                s_clr_cent = 1'b1;
            end
            ST_LEAP: begin
                w_acent.vld = (r_cnt < CNT_W'(A_W));
                w_acent.dat = r_ash[A_W-1];
            end
            ST_FIX: begin
            end
            ST_MONTH: begin
            end
            ST_OUT: begin
                s_load_out = !r_ovld || i_out_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------- serial dividers
    esc_divcell #(.DIVISOR(DIV_MIN)) u_div_sec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (s_accept),
        .i_str   (w_src),
        .o_str   (w_s1),
        .o_rem   (w_sec)
    );

    esc_divcell #(.DIVISOR(DIV_MIN)) u_div_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (s_accept),
        .i_str   (w_s1),
        .o_str   (w_s2),
        .o_rem   (w_min)
    );

    esc_divcell #(.DIVISOR(DIV_HOUR)) u_div_hour (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (s_accept),
        .i_str   (w_s2),
        .o_str   (w_s3),
        .o_rem   (w_hour)
    );

    esc_divcell #(.DIVISOR(DIV_YEAR)) u_div_year (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (s_accept),
        .i_str   (w_s3),
        .o_str   (w_s365),
        .o_rem   (w_r365)
    );

    esc_divcell #(.DIVISOR(DIV_WEEK)) u_div_week (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (s_accept),
        .i_str   (w_s3),
        .o_str   (),
        .o_rem   (w_d7)
    );

    esc_divcell #(.DIVISOR(DIV_CENT)) u_div_cent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (s_clr_cent),
        .i_str   (w_acent),
        .o_str   (w_s25),
        .o_rem   (w_c25)
    );

    // ------------------------------------------------------ year correction
    assign w_y0    = Y_W'(r_q) + Y_W'(EPOCH_YEAR - 1);
    assign w_extra = r_y0[Y_W-1:2] - A_W'(r_b) + A_W'(r_b >> 2)
                   - A_W'(LEAPS_BEFORE_EPOCH);
    assign w_corr  = (A_W'(w_r365) < w_extra);
    assign w_fwd   = R_W'(w_r365) - R_W'(w_extra);
    assign w_wrap  = (r_y0[1:0] == 2'd3) && (w_c25 == CENT_W'(DIV_CENT - 1));
    assign w_leap0 = (r_y0[1:0] == 2'd0)
                   && ((w_c25 != '0) || (r_b[1:0] == 2'd0));
    assign w_leap1 = (r_y0[1:0] == 2'd3)
                   && (!w_wrap || ((r_b[1:0] + 2'd1) == 2'd0));
    assign w_back  = R_W'(w_r365) + R_W'(DAYS_PER_YEAR) + R_W'(w_leap0)
                   - R_W'(w_extra);

    always_comb begin
        if (w_corr) begin
            n_rem  = w_back[R_W-1] ? '0 : w_back;
            n_leap = w_leap0;
            n_yr   = 8'(r_y0 - Y_W'(BASE_YEAR));
        end else begin
            n_rem  = w_fwd;
            n_leap = w_leap1;
            n_yr   = 8'(r_y0 - Y_W'(BASE_YEAR) + Y_W'(1));
        end
    end

    assign w_len  = MONTH_LEN[r_mon] + 5'((r_mon == MONTH_FEB) && r_leap);
    assign w_wday = (w_d7 >= WEEK_W'(DIV_WEEK - EPOCH_WDAY))
                  ? 3'(w_d7 - WEEK_W'(DIV_WEEK - EPOCH_WDAY))
                  : 3'(w_d7 + WEEK_W'(EPOCH_WDAY));

    // ------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        if (s_accept || (r_state == ST_YEAR)) begin
            r_cnt <= '0;
        end else if ((r_state == ST_STREAM) || (r_state == ST_LEAP)) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end

        if (s_accept) begin
            r_tsh <= i_epoch_seconds;
        end else if (r_state == ST_STREAM) begin
            r_tsh <= {r_tsh[TIME_BITS-2:0], 1'b0};
        end

        if (w_s365.vld) begin
            r_q <= {r_q[Q_W-2:0], w_s365.dat};
        end

        if (r_state == ST_YEAR) begin
            r_y0  <= w_y0;
            r_ash <= w_y0[Y_W-1:2];
        end else if (r_state == ST_LEAP) begin
            r_ash <= {r_ash[A_W-2:0], 1'b0};
        end

        if (w_s25.vld) begin
            r_b <= {r_b[B_W-2:0], w_s25.dat};
        end

        if (r_state == ST_FIX) begin
            r_rem  <= n_rem;
            r_leap <= n_leap;
            r_yr   <= n_yr;
            r_doy  <= 9'(n_rem + R_W'(1));
            r_mon  <= '0;
        end else if ((r_state == ST_MONTH) && !s_month_done) begin
            r_rem <= r_rem - R_W'(w_len);
            r_mon <= r_mon + 4'd1;
        end

        if (s_load_out) begin
            r_out_sec  <= w_sec;
            r_out_min  <= w_min;
            r_out_hour <= w_hour;
            r_out_dom  <= 5'(r_rem + R_W'(1));
            r_out_mon  <= r_mon;
            r_out_yr   <= r_yr;
            r_out_doy  <= r_doy;
            r_out_wday <= w_wday;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (s_load_out) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end

    assign o_out_valid        = r_ovld;
    assign o_second_of_minute = r_out_sec;
    assign o_minute_of_hour   = r_out_min;
    assign o_hour_of_day      = r_out_hour;
    assign o_day_of_month     = r_out_dom;
    assign o_month_index      = r_out_mon;
    assign o_years_since_1900 = r_out_yr;
    assign o_day_of_year      = r_out_doy;
    assign o_weekday          = r_out_wday;

    // ----------------------------------------------------------- assertions
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while a conversion is under way");

    a_year_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_STREAM) && s_stream_end) |-> w_s365.vld)
        else $error("year divider stream out of step with the stream counter");

    a_year_stream_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_YEAR) |-> !w_s365.vld)
        else $error("year divider still busy after the stream phase");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && r_ovld && !i_out_ready) |=> (r_state == ST_OUT))
        else $error("result dropped while the output register is stalled");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MONTH) |-> (r_mon <= MONTH_LAST))
        else $error("month scan ran past December");

endmodule

[tb/tb_epoch_seconds_to_calendar.sv]
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar
// Self-checking testbench for the epoch seconds to calendar converter. Each
// accepted request is converted by a behavioural calendar model held here
// and queued. Every result taken from the block is compared field by field
// with the oldest queued date. Directed tests cover the range ends, the
// time-of-day limits, the leap rules and the year estimate correction. Random
// tests cover the full range and dates near month and year boundaries, with
// random gaps and stalls, drain pauses, and a final part with no idling.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned SECS_PER_DAY  = 86400;
    localparam longint unsigned SECS_PER_HOUR = 3600;
    localparam longint unsigned FIRST_YEAR    = 1970;
    localparam longint unsigned YEAR_OFFSET   = 1900;
    localparam longint unsigned YEAR_DAYS     = 365;
    localparam longint unsigned MAX_SECONDS   = 64'hFFFF_FFFF;
    localparam int unsigned     DRAIN_CYCLES  = 80;

    localparam int unsigned month_days [0:11] = '{
        31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
    };

    typedef struct packed {
        logic [5:0] second_of_minute;
        logic [5:0] minute_of_hour;
        logic [4:0] hour_of_day;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [7:0] years_since_1900;
        logic [8:0] day_of_year;
        logic [2:0] weekday;
    } date_fields_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_epoch_seconds = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [5:0]  o_second_of_minute;
    logic [5:0]  o_minute_of_hour;
    logic [4:0]  o_hour_of_day;
    logic [4:0]  o_day_of_month;
    logic [3:0]  o_month_index;
    logic [7:0]  o_years_since_1900;
    logic [8:0]  o_day_of_year;
    logic [2:0]  o_weekday;

    date_fields_t pending_dates [$];
    int unsigned  failures = 0;
    int unsigned  idle_pct = 0;

    epoch_seconds_to_calendar u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_day_of_month     (o_day_of_month),
        .o_month_index      (o_month_index),
        .o_years_since_1900 (o_years_since_1900),
        .o_day_of_year      (o_day_of_year),
        .o_weekday          (o_weekday)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit is_leap(input longint unsigned year);
        return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    endfunction

    function automatic longint unsigned leaps_upto(input longint unsigned year);
        return year / 4 - year / 100 + year / 400;
    endfunction

    function automatic date_fields_t to_calendar(input logic [31:0] secs);
        date_fields_t    d;
        longint unsigned days;
        longint unsigned sod;
        longint unsigned year;
        longint unsigned start;
        longint unsigned rest;
        longint unsigned len;
        int unsigned     mon;
        days  = longint'(secs) / SECS_PER_DAY;
        sod   = longint'(secs) % SECS_PER_DAY;
        year  = FIRST_YEAR + days / YEAR_DAYS;
        start = (year - FIRST_YEAR) * YEAR_DAYS + leaps_upto(year - 1)
                - leaps_upto(FIRST_YEAR - 1);
        if (days < start) begin
            year  = year - 1;
            start = start - YEAR_DAYS - is_leap(year);
        end
        rest = days - start;
        d.years_since_1900 = 8'(year - YEAR_OFFSET);
        d.day_of_year      = 9'(rest + 1);
        for (mon = 0; mon < 11; mon++) begin
            len = month_days[mon] + ((mon == 1 && is_leap(year)) ? 1 : 0);
            if (rest < len) break;
            rest = rest - len;
        end
        d.month_index      = 4'(mon);
        d.day_of_month     = 5'(rest + 1);
        d.hour_of_day      = 5'(sod / SECS_PER_HOUR);
        d.minute_of_hour   = 6'((sod % SECS_PER_HOUR) / 60);
        d.second_of_minute = 6'(sod % 60);
        d.weekday          = 3'((days + 4) % 7);
        return d;
    endfunction

    // month is 0-based, day 1-based
    function automatic longint unsigned epoch_of(input int unsigned year,
                                                 input int unsigned month,
                                                 input int unsigned day);
        longint unsigned days;
        days = 0;
        for (int unsigned y = FIRST_YEAR; y < year; y++)
            days += YEAR_DAYS + is_leap(y);
        for (int unsigned m = 0; m < month; m++)
            days += month_days[m] + ((m == 1 && is_leap(year)) ? 1 : 0);
        days += day - 1;
        return days * SECS_PER_DAY;
    endfunction

    task automatic send_seconds(input longint unsigned secs);
        @(negedge i_clk);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_epoch_seconds <= secs[31:0];
        do @(posedge i_clk); while (!o_in_ready);
        pending_dates.push_back(to_calendar(secs[31:0]));
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : check_dates
        date_fields_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_dates.size() == 0) begin
                $error("result with no request outstanding");
                failures++;
            end else begin
                want = pending_dates.pop_front();
                check_field("second_of_minute", want.second_of_minute,
                            o_second_of_minute);
                check_field("minute_of_hour", want.minute_of_hour, o_minute_of_hour);
                check_field("hour_of_day", want.hour_of_day, o_hour_of_day);
                check_field("day_of_month", want.day_of_month, o_day_of_month);
                check_field("month_index", want.month_index, o_month_index);
                check_field("years_since_1900", want.years_since_1900,
                            o_years_since_1900);
                check_field("day_of_year", want.day_of_year, o_day_of_year);
                check_field("weekday", want.weekday, o_weekday);
            end
        end
    end

    initial begin : out_ready_gen
        int unsigned stall;
        forever begin
            @(negedge i_clk);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                stall = $urandom_range(1, 5);
                i_out_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic test_range_ends();
        send_seconds(0);
        send_seconds(MAX_SECONDS);
        send_seconds(MAX_SECONDS - 1);
        send_seconds(64'h8000_0000);
        send_seconds(64'h7FFF_FFFF);
        send_seconds(epoch_of(2106, 0, 1));
    endtask

    task automatic test_time_of_day_limits();
        send_seconds(SECS_PER_DAY - 1);
        send_seconds(SECS_PER_DAY);
        send_seconds(epoch_of(1999, 11, 31) + SECS_PER_DAY - 1);
        send_seconds(epoch_of(2000, 0, 1));
    endtask

    task automatic test_leap_rules();
        send_seconds(epoch_of(1972, 1, 29));
        send_seconds(epoch_of(1972, 11, 31) + SECS_PER_DAY - 1);
        send_seconds(epoch_of(2000, 1, 29) + 43210);
        send_seconds(epoch_of(2000, 11, 31));
        send_seconds(epoch_of(2100, 1, 28));
        send_seconds(epoch_of(2100, 2, 1));
        send_seconds(epoch_of(2100, 11, 31));
    endtask

    task automatic test_year_estimate();
        send_seconds(4 * YEAR_DAYS * SECS_PER_DAY);
        send_seconds((4 * YEAR_DAYS - 1) * SECS_PER_DAY + 7);
        send_seconds(100 * YEAR_DAYS * SECS_PER_DAY);
        send_seconds(136 * YEAR_DAYS * SECS_PER_DAY);
        send_seconds(epoch_of(2069, 11, 31));
    endtask

    task automatic test_random_seconds(input int unsigned count);
        repeat (count) send_seconds($urandom);
    endtask

    task automatic test_calendar_boundaries(input int unsigned count);
        longint          base;
        longint          offset;
        longint          secs;
        int unsigned     month;
        repeat (count) begin
            month  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2)
                                                  : $urandom_range(0, 11);
            base   = longint'(epoch_of($urandom_range(1970, 2105), month, 1));
            offset = longint'($urandom_range(0, 4 * SECS_PER_DAY))
                     - longint'(2 * SECS_PER_DAY);
            secs   = base + offset;
            if (secs < 0 || secs > longint'(MAX_SECONDS))
                secs = base;
            send_seconds(longint'(secs));
        end
    endtask

    task automatic test_drain_pauses(input int unsigned batches);
        repeat (batches) begin
            repeat ($urandom_range(1, 8)) send_seconds($urandom);
            wait_for_drain();
        end
    endtask

    initial begin : main
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 30;
        test_range_ends();
        test_time_of_day_limits();
        test_leap_rules();
        test_year_estimate();
        test_random_seconds(600);
        test_calendar_boundaries(250);
        test_drain_pauses(12);
        idle_pct = 10;
        test_random_seconds(100);
        idle_pct = 0;
        test_calendar_boundaries(100);
        test_random_seconds(150);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending_dates.size() == 0) begin
            $display("epoch_seconds_to_calendar regression: pass");
        end else begin
            $display("epoch_seconds_to_calendar regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(10_000_000);
        $display("epoch_seconds_to_calendar regression: fail");
        $finish;
    end

endmodule

[filelist.f]
src/esc_pkg.sv
src/esc_divcell.sv
src/epoch_seconds_to_calendar.sv
tb/tb_epoch_seconds_to_calendar.sv
